// ----- rtl/gcpg_pkg.sv -----
`default_nettype none
package gcpg_pkg;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STOCK_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_COUNT = 1'd1;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GENERATE = 1'b1;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned TCOUNT_W = 7;

  typedef struct packed {
    logic operation;
    logic [5:0] type_slot;
    logic [15:0] piece_length;
    logic [15:0] piece_demand;
  } in_word_t;

  typedef struct packed {
    logic [5:0] type_out;
    logic [15:0] piece_count;
    logic last_of_pattern;
    logic all_met;
    logic stuck;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/gcpg_if.sv -----
`default_nettype none
interface gcpg_in_if;
  logic valid;
  logic ready;
  gcpg_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gcpg_out_if;
  logic valid;
  logic ready;
  gcpg_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/greedy_cutting_pattern_generator_core.sv -----
`default_nettype none
// Greedy cutting pattern generator.
// in: words with operation 0 (load type_slot length/demand) or 1 (generate).
// out: per generate, type_count words (clamped to 1..MAX_TYPES), type 0 first,
// last_of_pattern on the final one; all_met and stuck repeat on every word.
// cfg: wr_en/wr_index/wr_data; index 0 stock_length, 1 type_count; write only
// while idle.
// A load is taken while idle; the next word can follow right after.
// A generate: the accept, a scan of types from n-1 down to the top type with
// demand, each type from there down cut through the serial divider (a skipped
// or zero-length type bypasses it), a demand check over all types, the output
// words plus receiver stalls, then a clear of the count memory. Throughput is
// one item at a time.
// Reset: stock_length 1000, type_count 1; the count memory is cleared by a
// pass over all MAX_TYPES entries during which no word is accepted.
// A stalled receiver holds the output word; the pattern drain waits.
module greedy_cutting_pattern_generator_core #(
  parameter int unsigned MAX_TYPES = 64,
  parameter int unsigned LEN_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  gcpg_in_if.sink in_ch,
  gcpg_out_if.source out_ch,
  input wire logic wr_en,
  input wire logic [gcpg_pkg::CFG_IDX_W-1:0] wr_index,
  input wire logic [gcpg_pkg::CFG_DATA_W-1:0] wr_data
);
  localparam int unsigned AW = $clog2(MAX_TYPES);
  localparam int unsigned NW = $clog2(MAX_TYPES + 1);
  localparam int unsigned CW = gcpg_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_CUT_RD, S_CUT_DIV, S_CUT_WAIT,
    S_CUT_WR, S_MET_RD, S_MET_CHK, S_OUT_RD, S_OUT_SHOW
  } state_t;

  state_t state;
  // length and demand share an address: one memory of pairs
  logic [LEN_BITS+CW-1:0] tab_mem [MAX_TYPES];
  logic [CW-1:0] cnt_mem [MAX_TYPES];
  logic [LEN_BITS+CW-1:0] tab_rd;
  logic [CW-1:0] cnt_rd;
  logic [AW-1:0] tab_addr;
  logic [AW-1:0] cnt_addr;
  logic tab_we, cnt_we;
  logic [LEN_BITS+CW-1:0] tab_wd;
  logic [CW-1:0] cnt_wd;

  logic [15:0] stock_length;
  logic [gcpg_pkg::TCOUNT_W-1:0] type_count;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] idx;
  logic [AW-1:0] last_idx;
  logic [LEN_BITS-1:0] room;
  logic [LEN_BITS-1:0] cur_len;
  logic [CW-1:0] cur_dem;
  logic [CW-1:0] q;
  logic is_top, stuck, met;
  gcpg_pkg::div_req_t dreq;
  gcpg_pkg::div_rsp_t drsp;

  always_comb begin
    if (type_count == '0) n_eff = NW'(1);
    else if (32'(type_count) > MAX_TYPES) n_eff = NW'(MAX_TYPES);
    else n_eff = NW'(type_count);
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_addr] <= tab_wd;
    tab_rd <= tab_mem[tab_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_addr];
  end

  gcpg_divider #(.W(LEN_BITS)) u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cur_len = tab_rd[LEN_BITS+CW-1:CW];
  assign cur_dem = tab_rd[CW-1:0];

  always_comb begin
    tab_we = 1'b0;
    cnt_we = 1'b0;
    tab_addr = idx[AW-1:0];
    cnt_addr = idx[AW-1:0];
    tab_wd = {cur_len, cur_dem - q};
    cnt_wd = q;
    dreq.start = 1'b0;
    dreq.dividend = 32'(room);
    dreq.divisor = 32'(cur_len);
    unique case (state)
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wd = '0;
      end
      S_IDLE: begin
        tab_addr = AW'(in_ch.data.type_slot);
        tab_wd = {LEN_BITS'(in_ch.data.piece_length), in_ch.data.piece_demand};
        tab_we = in_ch.valid && in_ch.data.operation == gcpg_pkg::OP_LOAD
                 && 32'(in_ch.data.type_slot) < MAX_TYPES;
        cnt_addr = '0;
      end
      S_CUT_DIV: dreq.start = (cur_len != '0) && (is_top || room >= cur_len);
      S_CUT_WR: begin
        tab_we = 1'b1;
        cnt_we = 1'b1;
      end
      S_OUT_SHOW: cnt_addr = idx[AW-1:0] + 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      stock_length <= 16'd1000;
      type_count <= gcpg_pkg::TCOUNT_W'(1);
      out_ch.valid <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          gcpg_pkg::REG_STOCK_LENGTH: stock_length <= wr_data;
          gcpg_pkg::REG_TYPE_COUNT: type_count <= wr_data[gcpg_pkg::TCOUNT_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == NW'(MAX_TYPES - 1)) begin
            idx <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.data.operation == gcpg_pkg::OP_GENERATE) begin
            idx <= n_eff - 1'b1;
            last_idx <= AW'(n_eff - 1'b1);
            stuck <= 1'b0;
            met <= 1'b1;
            room <= LEN_BITS'(stock_length);
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (cur_dem != '0) begin
            is_top <= 1'b1;
            state <= S_CUT_RD;
          end else if (idx == '0) begin
            state <= S_MET_RD;
          end else begin
            idx <= idx - 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_CUT_RD: state <= S_CUT_DIV;
        S_CUT_DIV: begin
          if (is_top && cur_len > room) stuck <= 1'b1;
          if (!is_top && room < cur_len) begin
            q <= '0;
            // not cut: count stays zero, demand unchanged
            state <= S_CUT_WR;
          end else if (cur_len == '0) begin
            q <= cur_dem;
            state <= S_CUT_WR;
          end else begin
            state <= S_CUT_WAIT;
          end
        end
        S_CUT_WAIT: begin
          if (drsp.done) begin
            q <= (drsp.quotient > 32'(cur_dem)) ? cur_dem : CW'(drsp.quotient);
            state <= S_CUT_WR;
          end
        end
        S_CUT_WR: begin
          room <= room - LEN_BITS'(32'(q) * 32'(cur_len));
          is_top <= 1'b0;
          if (idx == '0) begin
            idx <= n_eff - 1'b1;
            state <= S_MET_RD;
          end else begin
            idx <= idx - 1'b1;
            state <= S_CUT_RD;
          end
        end
        S_MET_RD: state <= S_MET_CHK;
        S_MET_CHK: begin
          if (cur_dem != '0) met <= 1'b0;
          if (idx == '0) begin
            state <= S_OUT_RD;
          end else begin
            idx <= idx - 1'b1;
            state <= S_MET_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_SHOW;
        S_OUT_SHOW: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.data.type_out <= gcpg_pkg::SLOT_W'(idx);
            out_ch.data.piece_count <= cnt_rd;
            out_ch.data.last_of_pattern <= idx[AW-1:0] == last_idx;
            out_ch.data.all_met <= met;
            out_ch.data.stuck <= stuck;
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (idx[AW-1:0] == last_idx) begin
              idx <= '0;
              state <= S_CLEAR;
            end else begin
              idx <= idx + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("ready outside idle");
  a_out_only_drain: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_OUT_SHOW) else $error("output outside drain");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.start |=> state == S_CUT_WAIT) else $error("divider start misplaced");
  a_stuck_top: assert property (@(posedge clk) disable iff (rst)
    $rose(stuck) |-> $past(is_top)) else $error("stuck off top");
`endif
endmodule
`default_nettype wire

// ----- rtl/gcpg_divider.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle
module gcpg_divider #(
  parameter int unsigned W = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire gcpg_pkg::div_req_t req,
  output gcpg_pkg::div_rsp_t rsp
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0] quo;
  logic [W-1:0] den;
  logic [W:0] rem;
  logic [CW-1:0] cnt;
  logic busy;
  logic done;
  logic [W:0] trial;
  logic [W:0] shifted;

  always_comb begin
    shifted = {rem[W-1:0], quo[W-1]};
    trial = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CW'(W);
        quo <= req.dividend[W-1:0];
        den <= req.divisor[W-1:0];
        rem <= '0;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial;
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = 32'(quo);
endmodule
`default_nettype wire
